// File: rtl/core/prr_pkg.sv
package prr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 18;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS       = PROD_BITS + 8;
    localparam int ROUND_SHIFT    = COEF_BITS - 4;
    localparam int COEF_ADDR_BITS = 12;
    localparam int HIST_ADDR_BITS = 8;
    localparam int HIST_WORD_BITS = 2 * SAMPLE_BITS;
    localparam int PHASE_BITS     = 6;
    localparam int L_BITS         = 7;
    localparam int M_BITS         = 10;
    localparam int TPP_BITS       = 9;
    localparam int QUO_BITS       = 10;
    localparam int S_TDATA_BITS   = 64;
    localparam int M_TDATA_BITS   = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 10;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERP = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECIM  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAPS   = 2'd2;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

endpackage

// File: rtl/core/prr_coef_ram.sv
module prr_coef_ram (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic        [prr_pkg::COEF_ADDR_BITS-1:0]   i_waddr,
    input  logic signed [prr_pkg::COEF_BITS-1:0]        i_wdata,
    input  logic        [prr_pkg::COEF_ADDR_BITS-1:0]   i_raddr,
    output logic signed [prr_pkg::COEF_BITS-1:0]        o_rdata
);

    logic signed [prr_pkg::COEF_BITS-1:0] r_mem [2**prr_pkg::COEF_ADDR_BITS];
    logic signed [prr_pkg::COEF_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/prr_hist_ram.sv
module prr_hist_ram (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_we,
    input  logic        [prr_pkg::HIST_ADDR_BITS-1:0]   i_waddr,
    input  logic        [prr_pkg::HIST_WORD_BITS-1:0]   i_wdata,
    input  logic        [prr_pkg::HIST_ADDR_BITS-1:0]   i_raddr,
    output logic signed [prr_pkg::SAMPLE_BITS-1:0]      o_re,
    output logic signed [prr_pkg::SAMPLE_BITS-1:0]      o_im
);

    logic [prr_pkg::HIST_WORD_BITS-1:0] r_mem [2**prr_pkg::HIST_ADDR_BITS];
    logic [prr_pkg::HIST_WORD_BITS-1:0] r_rdata;
    logic                               r_rd_ok;
    logic [prr_pkg::HIST_ADDR_BITS:0]   r_fill;

    // entries are written in order from zero after reset, so a count of
    // written entries marks which ones still read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_we && !r_fill[prr_pkg::HIST_ADDR_BITS]) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
        r_rd_ok <= ({1'b0, i_raddr} < r_fill);
    end

    assign o_re = r_rd_ok ? r_rdata[prr_pkg::SAMPLE_BITS-1:0] : '0;
    assign o_im = r_rd_ok ? r_rdata[prr_pkg::HIST_WORD_BITS-1:prr_pkg::SAMPLE_BITS] : '0;

endmodule

// File: rtl/core/prr_mac.sv
module prr_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  prr_pkg::t_mac_ctl                       i_ctl,
    input  logic signed [prr_pkg::COEF_BITS-1:0]    i_coef,
    input  logic signed [prr_pkg::SAMPLE_BITS-1:0]  i_re,
    input  logic signed [prr_pkg::SAMPLE_BITS-1:0]  i_im,
    output logic                                    o_busy,
    output logic signed [prr_pkg::SAMPLE_BITS-1:0]  o_re,
    output logic signed [prr_pkg::SAMPLE_BITS-1:0]  o_im
);

    localparam int QBITS = prr_pkg::ACC_BITS - prr_pkg::ROUND_SHIFT;

    logic                                  r_p_valid;
    logic signed [prr_pkg::PROD_BITS-1:0]  r_p_re;
    logic signed [prr_pkg::PROD_BITS-1:0]  r_p_im;
    logic signed [prr_pkg::ACC_BITS-1:0]   r_acc_re;
    logic signed [prr_pkg::ACC_BITS-1:0]   r_acc_im;

    // round half up, then saturate
    function automatic logic signed [prr_pkg::SAMPLE_BITS-1:0] round_sat(
        input logic signed [prr_pkg::ACC_BITS-1:0] acc
    );
        logic signed [prr_pkg::ACC_BITS-1:0] t;
        logic signed [QBITS-1:0]             q;
        logic signed [QBITS-1:0]             qmax;
        logic signed [QBITS-1:0]             qmin;
        t    = acc + (prr_pkg::ACC_BITS'(1) <<< (prr_pkg::ROUND_SHIFT - 1));
        q    = QBITS'(t >>> prr_pkg::ROUND_SHIFT);
        qmax = QBITS'((1 << (prr_pkg::SAMPLE_BITS - 1)) - 1);
        qmin = -qmax - QBITS'(1);
        if (q > qmax) begin
            round_sat = qmax[prr_pkg::SAMPLE_BITS-1:0];
        end else if (q < qmin) begin
            round_sat = qmin[prr_pkg::SAMPLE_BITS-1:0];
        end else begin
            round_sat = q[prr_pkg::SAMPLE_BITS-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_re <= prr_pkg::PROD_BITS'(i_coef) * prr_pkg::PROD_BITS'(i_re);
        r_p_im <= prr_pkg::PROD_BITS'(i_coef) * prr_pkg::PROD_BITS'(i_im);
        if (i_ctl.clear) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_p_valid) begin
            r_acc_re <= r_acc_re + prr_pkg::ACC_BITS'(r_p_re);
            r_acc_im <= r_acc_im + prr_pkg::ACC_BITS'(r_p_im);
        end
    end

    assign o_busy = r_p_valid;
    assign o_re   = round_sat(r_acc_re);
    assign o_im   = round_sat(r_acc_im);

endmodule

// File: rtl/core/prr_phase_div.sv
module prr_phase_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [prr_pkg::QUO_BITS-1:0]        i_dividend,
    input  logic [prr_pkg::L_BITS-1:0]          i_divisor,
    output logic                                o_busy,
    output logic [prr_pkg::QUO_BITS-1:0]        o_quo,
    output logic [prr_pkg::PHASE_BITS-1:0]      o_rem
);

    localparam int CNT_BITS = $clog2(prr_pkg::QUO_BITS + 1);

    logic                               r_busy;
    logic [CNT_BITS-1:0]                r_cnt;
    logic [prr_pkg::QUO_BITS-1:0]       r_quo;
    logic [prr_pkg::PHASE_BITS-1:0]     r_rem;
    logic [prr_pkg::L_BITS-1:0]         r_div;
    logic [prr_pkg::L_BITS-1:0]         w_trial;
    logic                               w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[prr_pkg::QUO_BITS-1]};
    assign w_ge    = (w_trial >= r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(prr_pkg::QUO_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[prr_pkg::QUO_BITS-2:0], w_ge};
            r_rem <= w_ge ? prr_pkg::PHASE_BITS'(w_trial - r_div)
                          : w_trial[prr_pkg::PHASE_BITS-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: rtl/core/polyphase_rational_resampler.sv
// channel   dir   handshake                          payload
// s_axis    in    i_s_axis_tvalid / o_s_axis_tready  tdata: samples, coefficient; tuser: mode
// m_axis    out   o_m_axis_tvalid / i_m_axis_tready  tdata: out_re, out_im; tlast: last
// cfg       in    i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//
// The input stays ready after a coefficient transfer or a skipped sample.
// For each output one MAC pair walks the taps at one per cycle through both memory
// ports, then a divider updates the phase. After a smaller interp_factor the phase
// is first reduced, one step a cycle.
// Reset is synchronous; history reads as zero until written, no clearing pass.
// A stalled output holds the last result and the next one waits in the MAC.
module polyphase_rational_resampler (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [15:0] sample_re, [31:16] sample_im, [43:32] coef_index, [61:44] coef_value
    input  logic [prr_pkg::S_TDATA_BITS-1:0]        i_s_axis_tdata,
    // [0] mode
    input  logic                                    i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // [15:0] out_re, [31:16] out_im
    output logic [prr_pkg::M_TDATA_BITS-1:0]        o_m_axis_tdata,
    output logic                                    o_m_axis_tlast,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [prr_pkg::CFG_INDEX_BITS-1:0]      i_cfg_index,
    input  logic [prr_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_MAC    = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    localparam int SB = prr_pkg::SAMPLE_BITS;

    logic [2:0]                             r_state;
    logic [prr_pkg::L_BITS-1:0]             r_interp;
    logic [prr_pkg::M_BITS-1:0]             r_decim;
    logic [prr_pkg::TPP_BITS-1:0]           r_taps;
    logic [prr_pkg::HIST_ADDR_BITS-1:0]     r_ptr;
    logic [prr_pkg::PHASE_BITS-1:0]         r_phase;
    logic [prr_pkg::QUO_BITS-1:0]           r_skip;
    logic [prr_pkg::TPP_BITS-1:0]           r_k;
    logic [prr_pkg::COEF_ADDR_BITS-1:0]     r_base;
    logic [prr_pkg::PHASE_BITS-1:0]         r_n;
    logic                                   r_issue_d1;
    logic                                   r_m_valid;
    logic [prr_pkg::M_TDATA_BITS-1:0]       r_m_data;
    logic                                   r_m_last;

    logic [prr_pkg::L_BITS-1:0]             w_l;
    logic [prr_pkg::M_BITS-1:0]             w_m;
    logic [prr_pkg::TPP_BITS-1:0]           w_tpp;
    logic                                   w_s_acc;
    logic                                   w_coef_we;
    logic                                   w_hist_we;
    logic [prr_pkg::PHASE_BITS+prr_pkg::TPP_BITS-1:0] w_base_full;
    logic [prr_pkg::HIST_ADDR_BITS-1:0]     w_hist_raddr;
    logic [prr_pkg::COEF_ADDR_BITS-1:0]     w_coef_raddr;
    logic                                   w_issue;
    prr_pkg::t_mac_ctl                      w_mac_ctl;
    logic                                   w_mac_busy;
    logic signed [SB-1:0]                   w_acc_re;
    logic signed [SB-1:0]                   w_acc_im;
    logic signed [prr_pkg::COEF_BITS-1:0]   w_coef;
    logic signed [SB-1:0]                   w_hist_re;
    logic signed [SB-1:0]                   w_hist_im;
    logic                                   w_div_start;
    logic                                   w_div_busy;
    logic [prr_pkg::QUO_BITS-1:0]           w_quo;
    logic [prr_pkg::PHASE_BITS-1:0]         w_rem;
    logic                                   w_last;
    logic                                   w_out_free;

    assign w_l = (r_interp == '0) ? prr_pkg::L_BITS'(1) :
                 (r_interp > prr_pkg::L_BITS'(64)) ? prr_pkg::L_BITS'(64) : r_interp;
    assign w_m = (r_decim == '0) ? prr_pkg::M_BITS'(1) :
                 (r_decim > prr_pkg::M_BITS'(512)) ? prr_pkg::M_BITS'(512) : r_decim;
    assign w_tpp = (r_taps < prr_pkg::TPP_BITS'(2)) ? prr_pkg::TPP_BITS'(2) :
                   (r_taps > prr_pkg::TPP_BITS'(256)) ? prr_pkg::TPP_BITS'(256) : r_taps;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp <= prr_pkg::L_BITS'(1);
            r_decim  <= prr_pkg::M_BITS'(1);
            r_taps   <= prr_pkg::TPP_BITS'(32);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                prr_pkg::CFG_INTERP: r_interp <= i_cfg_data[prr_pkg::L_BITS-1:0];
                prr_pkg::CFG_DECIM:  r_decim  <= i_cfg_data[prr_pkg::M_BITS-1:0];
                prr_pkg::CFG_TAPS:   r_taps   <= i_cfg_data[prr_pkg::TPP_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_coef_we = w_s_acc && (i_s_axis_tuser == prr_pkg::MODE_COEF);
    assign w_hist_we = w_s_acc && (i_s_axis_tuser == prr_pkg::MODE_SAMPLE);

    assign w_base_full  = prr_pkg::PHASE_BITS'(0) + r_phase * w_tpp;
    assign w_issue      = (r_state == S_MAC);
    assign w_hist_raddr = r_ptr - prr_pkg::HIST_ADDR_BITS'(1) - r_k[prr_pkg::HIST_ADDR_BITS-1:0];
    assign w_coef_raddr = r_base + prr_pkg::COEF_ADDR_BITS'(r_k);

    assign w_mac_ctl.clear = (r_state == S_REDUCE) && ({1'b0, r_phase} < w_l);
    assign w_mac_ctl.valid = r_issue_d1;

    assign w_div_start = (r_state == S_DRAIN) && !r_issue_d1 && !w_mac_busy;
    assign w_last      = (w_quo != '0) || (r_n == '1);
    assign w_out_free  = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ptr      <= '0;
            r_phase    <= '0;
            r_skip     <= '0;
            r_k        <= '0;
            r_n        <= '0;
            r_issue_d1 <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_issue_d1 <= w_issue;
            if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_hist_we) begin
                        r_ptr <= r_ptr + 1'b1;
                        if (r_skip != '0) begin
                            r_skip <= r_skip - 1'b1;
                        end else begin
                            r_state <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE: begin
                    if ({1'b0, r_phase} >= w_l) begin
                        r_phase <= r_phase - w_l[prr_pkg::PHASE_BITS-1:0];
                    end else begin
                        r_k     <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == w_tpp - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_phase <= w_rem;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        if (w_last) begin
                            r_skip  <= (w_quo == '0) ? '0 : w_quo - 1'b1;
                            r_n     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_n     <= r_n + 1'b1;
                            r_state <= S_REDUCE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_REDUCE) && ({1'b0, r_phase} < w_l)) begin
            r_base <= w_base_full[prr_pkg::COEF_ADDR_BITS-1:0];
        end
        if ((r_state == S_EMIT) && w_out_free) begin
            r_m_data <= {w_acc_im, w_acc_re};
            r_m_last <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;

    prr_coef_ram u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (i_s_axis_tdata[43:32]),
        .i_wdata (i_s_axis_tdata[61:44]),
        .i_raddr (w_coef_raddr),
        .o_rdata (w_coef)
    );

    prr_hist_ram u_hist_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_hist_we),
        .i_waddr (r_ptr),
        .i_wdata (i_s_axis_tdata[prr_pkg::HIST_WORD_BITS-1:0]),
        .i_raddr (w_hist_raddr),
        .o_re    (w_hist_re),
        .o_im    (w_hist_im)
    );

    prr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_coef),
        .i_re    (w_hist_re),
        .i_im    (w_hist_im),
        .o_busy  (w_mac_busy),
        .o_re    (w_acc_re),
        .o_im    (w_acc_im)
    );

    prr_phase_div u_phase_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (prr_pkg::QUO_BITS'(r_phase) + w_m),
        .i_divisor  (w_l),
        .o_busy     (w_div_busy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

endmodule

// File: rtl/core/prr_checker.sv
module prr_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    input  logic                                    o_s_axis_tready,
    input  logic [prr_pkg::S_TDATA_BITS-1:0]        i_s_axis_tdata,
    input  logic                                    i_s_axis_tuser,
    input  logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    input  logic [prr_pkg::M_TDATA_BITS-1:0]        o_m_axis_tdata,
    input  logic                                    o_m_axis_tlast,
    input  logic                                    i_cfg_valid,
    input  logic                                    o_cfg_ready,
    input  logic [prr_pkg::CFG_INDEX_BITS-1:0]      i_cfg_index,
    input  logic [prr_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);

    logic w_coef_xfer;

    assign w_coef_xfer = i_s_axis_tvalid && o_s_axis_tready
                         && (i_s_axis_tuser == prr_pkg::MODE_COEF);

    a_reset_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_coef_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_coef_xfer |=> !$rose(o_m_axis_tvalid))
        else $error("coefficient transfer produced a result");

    a_coef_ready_again: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_coef_xfer |=> o_s_axis_tready)
        else $error("input not ready after coefficient transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write not taken");

endmodule

bind polyphase_rational_resampler prr_checker u_prr_checker (.*);

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 600;
    localparam int MAX_OUTPUTS   = 64;
    localparam int MAX_L         = 64;
    localparam int MAX_M         = 512;
    localparam int MAX_TPP       = 256;
    localparam int COEF_DEPTH    = 4096;
    localparam int HIST_DEPTH    = 256;
    localparam longint SAT_MAX   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_MIN   = -SAT_MAX - 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] re;
        logic [SAMPLE_BITS-1:0] im;
        logic                   last;
    } result_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [S_TDATA_BITS-1:0]   s_axis_tdata = '0;
    logic                      s_axis_tuser = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // predictor state
    logic [L_BITS-1:0]          reg_interp = 7'd1;
    logic [M_BITS-1:0]          reg_decim = 10'd1;
    logic [TPP_BITS-1:0]        reg_taps = 9'd32;
    logic signed [COEF_BITS-1:0]   coef_mem [COEF_DEPTH];
    logic signed [SAMPLE_BITS-1:0] hist_re [HIST_DEPTH];
    logic signed [SAMPLE_BITS-1:0] hist_im [HIST_DEPTH];
    logic [HIST_ADDR_BITS-1:0]  hist_ptr = '0;
    int                         cur_phase = 0;
    int                         skip_left = 0;

    result_t pending_outputs [$];
    int      outputs_predicted = 0;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      hold_left = 0;
    int      stall_left = 0;
    bit      idle_on = 1'b0;
    result_t want;

    polyphase_rational_resampler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // long receiver hold-off, armed by the back-pressure test
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] round_sat(input longint acc);
        longint q;
        q = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (q > SAT_MAX) q = SAT_MAX;
        if (q < SAT_MIN) q = SAT_MIN;
        return q[SAMPLE_BITS-1:0];
    endfunction

    // push one sample into the history and queue every output it releases
    task automatic compute_outputs(input logic signed [SAMPLE_BITS-1:0] re,
                                   input logic signed [SAMPLE_BITS-1:0] im);
        int l;
        int m;
        int tpp;
        int n;
        int adv;
        bit more;
        logic [COEF_ADDR_BITS-1:0] caddr;
        logic [HIST_ADDR_BITS-1:0] hidx;
        longint acc_re;
        longint acc_im;
        result_t r;
        l   = clamp_int(int'(reg_interp), 1, MAX_L);
        m   = clamp_int(int'(reg_decim), 1, MAX_M);
        tpp = clamp_int(int'(reg_taps), 2, MAX_TPP);
        hist_re[hist_ptr] = re;
        hist_im[hist_ptr] = im;
        hist_ptr = hist_ptr + 1'b1;
        if (skip_left > 0) begin
            skip_left--;
            return;
        end
        if (cur_phase >= l) cur_phase = cur_phase % l;
        n = 0;
        adv = 0;
        more = 1'b1;
        while (more) begin
            acc_re = 0;
            acc_im = 0;
            for (int k = 0; k < tpp; k++) begin
                caddr = COEF_ADDR_BITS'(cur_phase * tpp + k);
                hidx  = hist_ptr - 1'b1 - HIST_ADDR_BITS'(k);
                acc_re += longint'(coef_mem[caddr]) * longint'(hist_re[hidx]);
                acc_im += longint'(coef_mem[caddr]) * longint'(hist_im[hidx]);
            end
            n++;
            cur_phase += m;
            adv = cur_phase / l;
            cur_phase = cur_phase % l;
            more = (adv == 0) && (n < MAX_OUTPUTS);
            r.re = round_sat(acc_re);
            r.im = round_sat(acc_im);
            r.last = !more;
            pending_outputs.push_back(r);
            outputs_predicted++;
        end
        skip_left = (adv > 0) ? adv - 1 : 0;
    endtask

    task automatic flag_mismatch(input string field, input int want_v, input int got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                     field, cycle_count, want_v, got_v);
    endtask

    task automatic check_output();
        if (pending_outputs.size() == 0) begin
            flag_mismatch("unexpected output", 0, int'(m_axis_tdata));
        end else begin
            want = pending_outputs.pop_front();
            if (m_axis_tdata[15:0] !== want.re)
                flag_mismatch("out_re", int'($signed(want.re)),
                              int'($signed(m_axis_tdata[15:0])));
            if (m_axis_tdata[31:16] !== want.im)
                flag_mismatch("out_im", int'($signed(want.im)),
                              int'($signed(m_axis_tdata[31:16])));
            if (m_axis_tlast !== want.last)
                flag_mismatch("tlast", int'(want.last), int'(m_axis_tlast));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_output();
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] rand_coef();
        if ($urandom_range(0, 7) == 0) return COEF_BITS'($urandom());
        return COEF_BITS'($urandom_range(0, 2047)) - COEF_BITS'(1024);
    endfunction

    task automatic send_item(input logic mode,
                             input logic [SAMPLE_BITS-1:0] re,
                             input logic [SAMPLE_BITS-1:0] im,
                             input logic [COEF_ADDR_BITS-1:0] cidx,
                             input logic [COEF_BITS-1:0] cval);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, cval, cidx, im, re};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (mode == MODE_COEF) coef_mem[cidx] = cval;
        else compute_outputs(re, im);
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] re,
                               input logic [SAMPLE_BITS-1:0] im);
        send_item(MODE_SAMPLE, re, im, COEF_ADDR_BITS'($urandom()), COEF_BITS'($urandom()));
    endtask

    task automatic send_coef(input logic [COEF_ADDR_BITS-1:0] cidx,
                             input logic [COEF_BITS-1:0] cval);
        send_item(MODE_COEF, SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()), cidx, cval);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_INTERP: reg_interp = val[L_BITS-1:0];
            CFG_DECIM:  reg_decim  = val[M_BITS-1:0];
            CFG_TAPS:   reg_taps   = val[TPP_BITS-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_rates(input int l, input int m, input int tpp);
        write_reg(CFG_INTERP, CFG_DATA_BITS'(l));
        write_reg(CFG_DECIM, CFG_DATA_BITS'(m));
        write_reg(CFG_TAPS, CFG_DATA_BITS'(tpp));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // fill the whole store so no tap is ever read before it is written
    task automatic test_coef_preload();
        idle_on = 1'b0;
        for (int i = 0; i < COEF_DEPTH; i++) send_coef(COEF_ADDR_BITS'(i), rand_coef());
        idle_on = 1'b1;
    endtask

    task automatic test_reset_config();
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'h0001);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
    endtask

    task automatic test_rounding_and_saturation();
        wait_idle();
        write_reg(CFG_TAPS, 10'd2);
        send_coef(12'd0, 18'd8192);
        send_coef(12'd1, 18'd0);
        send_sample(16'h0003, 16'hFFFD);
        send_sample(16'hFFFD, 16'h0005);
        send_sample(16'h0001, 16'hFFFF);
        send_coef(12'd0, 18'h1FFFF);
        send_coef(12'd1, 18'h1FFFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h7FFF, 16'h8000);
        send_coef(12'd0, 18'h20000);
        send_coef(12'd1, 18'h20000);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_coef(12'hFFF, 18'h20000);
        send_coef(12'd0, rand_coef());
        send_coef(12'd1, rand_coef());
    endtask

    task automatic test_register_limits();
        int start;
        int sent;
        wait_idle();
        write_reg(CFG_UNUSED, 10'h3FF);
        set_rates(0, 0, 1);
        repeat (3) send_sample(rand_sample(), rand_sample());
        wait_idle();
        set_rates(MAX_L, MAX_M, MAX_TPP);
        repeat (20) send_sample(rand_sample(), rand_sample());
        // full fan-out per sample, tap addresses wrap past the store
        wait_idle();
        write_reg(CFG_DECIM, 10'd1);
        start = outputs_predicted;
        sent = 0;
        while (sent < 12 && outputs_predicted - start < 100) begin
            send_sample(rand_sample(), rand_sample());
            sent++;
        end
        wait_idle();
        set_rates(1023, 1000, 300);
        repeat (4) send_sample(rand_sample(), rand_sample());
    endtask

    task automatic test_phase_reduction();
        int sent;
        wait_idle();
        set_rates(7, 3, 8);
        sent = 0;
        while (sent < 20 && (sent < 4 || cur_phase < 2 || skip_left != 0)) begin
            send_sample(rand_sample(), rand_sample());
            sent++;
        end
        wait_idle();
        write_reg(CFG_INTERP, 10'd2);
        repeat (4) send_sample(rand_sample(), rand_sample());
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        set_rates(4, 1, 8);
        idle_on = 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (40) send_sample(rand_sample(), rand_sample());
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic(input int phases, input int items);
        for (int p = 0; p < phases; p++) begin
            wait_idle();
            set_rates($urandom_range(1, 16), $urandom_range(1, 24), $urandom_range(2, 40));
            for (int i = 0; i < items; i++) begin
                if ($urandom_range(0, 7) == 0)
                    send_coef(COEF_ADDR_BITS'($urandom()), rand_coef());
                else
                    send_sample(rand_sample(), rand_sample());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_re[i] = '0;
            hist_im[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_coef_preload();
        test_reset_config();
        test_rounding_and_saturation();
        test_register_limits();
        test_phase_reduction();
        test_output_backpressure();
        test_random_traffic(5, 30);
        wait_idle();
        idle_on = 1'b0;
        test_random_traffic(1, 40);
        wait_idle();

        mismatch_count += pending_outputs.size();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
